FILE: design/drrx_pkg.sv
// Package for the DMX512/RDM frame receiver: sizes, byte codes, state and
// event encodings, and the structs passed between the receiver's modules.
// No dependencies.
package drrx_pkg;

  localparam int UNIVERSE_SLOTS   = 512;
  localparam int RDM_BUFFER_BYTES = 512;
  localparam int RDM_RING_ENTRIES = 4;
  localparam int UID_BYTES        = 6;

  localparam int POS_W  = 10;
  localparam int RING_W = 2;
  localparam int TS_W   = 32;
  localparam int CNT_W  = 32;
  localparam int SUM_W  = 16;
  localparam int DCNT_W = 5;
  localparam int MIN_W  = 10;
  localparam int CFG_W  = 10;

  localparam logic [7:0] SC_DMX         = 8'h00;
  localparam logic [7:0] SC_RDM         = 8'hCC;
  localparam logic [7:0] DISC_PREAMBLE  = 8'hFE;
  localparam logic [7:0] DISC_SEPARATOR = 8'hAA;
  localparam logic [7:0] RDM_SUB_START  = 8'h01;

  localparam logic [DCNT_W-1:0] DISC_UID_LEN = DCNT_W'(2 * UID_BYTES);
  localparam logic [DCNT_W-1:0] DISC_CS_LEN  = DCNT_W'(4);
  localparam logic [POS_W-1:0]  POS_UNIVERSE_END = POS_W'(UNIVERSE_SLOTS);
  localparam logic [POS_W-1:0]  POS_RDM_LIMIT    = POS_W'(RDM_BUFFER_BYTES);
  localparam logic [POS_W-1:0]  POS_SUB_CODE     = POS_W'(1);
  localparam logic [POS_W-1:0]  POS_LENGTH       = POS_W'(2);
  localparam logic [POS_W-1:0]  POS_MIN_LENGTH   = POS_W'(3);
  localparam logic [RING_W-1:0] RING_LAST        = RING_W'(RDM_RING_ENTRIES - 1);
  localparam logic [MIN_W-1:0]  MIN_SLOT_RESET   = MIN_W'(44);

  typedef enum logic [0:0] {
    REG_DISC_ENABLE = 1'b0,
    REG_MIN_SLOT    = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    REQ_BYTE  = 2'd0,
    REQ_BREAK = 2'd1,
    REQ_TICK  = 2'd2,
    REQ_NONE  = 2'd3
  } req_type_t;

  typedef enum logic [2:0] {
    BC_ZERO      = 3'd0,
    BC_RDM_SC    = 3'd1,
    BC_PREAMBLE  = 3'd2,
    BC_SEPARATOR = 3'd3,
    BC_OTHER     = 3'd4
  } byte_class_t;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'd0,
    ST_BREAK = 4'd1,
    ST_DMX   = 4'd2,
    ST_RDM   = 4'd3,
    ST_CSH   = 4'd4,
    ST_CSL   = 4'd5,
    ST_DPRE  = 4'd6,
    ST_DUID  = 4'd7,
    ST_DCS   = 4'd8
  } rx_state_t;

  typedef enum logic [2:0] {
    FE_NONE     = 3'd0,
    FE_DMX_DONE = 3'd1,
    FE_RDM_OK   = 3'd2,
    FE_RDM_BAD  = 3'd3,
    FE_DISC     = 3'd4,
    FE_OVERRUN  = 3'd5
  } frame_event_t;

  typedef struct packed {
    req_type_t       kind;
    byte_class_t     bclass;
    logic [7:0]      data;
    logic [TS_W-1:0] ts;
  } cmd_t;

  typedef struct packed {
    logic            we;
    cfg_reg_t        index;
    logic [CFG_W-1:0] data;
  } cfg_wr_t;

  typedef struct packed {
    logic             write_valid;
    logic             write_target;
    logic [POS_W-1:0] write_index;
    logic [7:0]       write_data;
    logic [RING_W-1:0] rdm_slot;
    frame_event_t     frame_event;
    logic [POS_W-1:0] last_frame_slots;
    logic [TS_W-1:0]  break_to_break_us;
    logic [TS_W-1:0]  slot_gap_us;
    rx_state_t        receive_state;
    logic [CNT_W-1:0] dmx_packet_count;
    logic [CNT_W-1:0] rdm_packet_count;
  } result_t;

endpackage

FILE: design/drrx_front.sv
// Front end of the frame receiver: takes UART events, classifies the request
// and the byte value, and holds them in a two-entry command queue.
// Depends on drrx_pkg.
module drrx_front import drrx_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  output logic            full,
  input  logic [1:0]      in_req_type,
  input  logic [7:0]      in_data_byte,
  input  logic [TS_W-1:0] in_timestamp_us,
  output logic            cmd_valid,
  input  logic            cmd_pop,
  output cmd_t            cmd
);

  cmd_t       q_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;
  logic [1:0] count_nxt;
  cmd_t       cmd_in;
  logic       do_push, do_pop;

  always_comb begin
    cmd_in.kind = req_type_t'(in_req_type);
    cmd_in.data = in_data_byte;
    cmd_in.ts   = in_timestamp_us;
    case (in_data_byte)
      SC_DMX:         cmd_in.bclass = BC_ZERO;
      SC_RDM:         cmd_in.bclass = BC_RDM_SC;
      DISC_PREAMBLE:  cmd_in.bclass = BC_PREAMBLE;
      DISC_SEPARATOR: cmd_in.bclass = BC_SEPARATOR;
      default:        cmd_in.bclass = BC_OTHER;
    endcase
  end

  assign full      = (count_r == 2'd2);
  assign cmd_valid = (count_r != 2'd0);
  assign do_push   = push && !full;
  assign do_pop    = cmd_pop && cmd_valid;
  assign cmd       = q_r[rd_ptr_r];

  always_comb begin
    case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + 2'd1;
      2'b01:   count_nxt = count_r - 2'd1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_push) wr_ptr_r <= !wr_ptr_r;
      if (do_pop)  rd_ptr_r <= !rd_ptr_r;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) q_r[wr_ptr_r] <= cmd_in;
  end

endmodule

FILE: design/drrx_engine.sv
// Back end of the frame receiver: the framing state machine, checksum, ring
// head, timing measurements and packet counters. One command per cycle while the result queue has room.
// Depends on drrx_pkg.
module drrx_engine import drrx_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  cfg_wr_t cfg_wr,
  input  logic    cmd_valid,
  output logic    cmd_pop,
  input  cmd_t    cmd,
  input  logic    res_ready,
  output logic    res_push,
  output result_t res
);

  logic              disc_en_r;
  logic [MIN_W-1:0]  min_slot_r;

  rx_state_t         state_r, state_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [RING_W-1:0] ring_r, ring_nxt;
  logic [DCNT_W-1:0] dcnt_r, dcnt_nxt;
  logic [7:0]        len_r, len_nxt;
  logic [7:0]        sub_r, sub_nxt;
  logic [TS_W-1:0]   last_time_r, last_time_nxt;
  logic [TS_W-1:0]   brk_time_r, brk_time_nxt;
  logic [TS_W-1:0]   dmx_brk_r, dmx_brk_nxt;
  logic              brk_was_dmx_r, brk_was_dmx_nxt;
  logic [TS_W-1:0]   gap_r, gap_nxt;
  logic [POS_W-1:0]  slots_r, slots_nxt;
  logic [TS_W-1:0]   b2b_r, b2b_nxt;
  logic [CNT_W-1:0]  dmx_cnt_r, dmx_cnt_nxt;
  logic [CNT_W-1:0]  rdm_cnt_r, rdm_cnt_nxt;

  logic              fire;
  logic              rdm_side, overrun, tick_expired, rdm_len_hit;
  logic [TS_W-1:0]   elapsed, gap_clamped;
  logic [POS_W-1:0]  pos_inc;
  logic [7:0]        len_eff;
  logic [DCNT_W-1:0] dcnt_inc;
  logic [SUM_W-1:0]  sum_add, sum_csh, sum_csl;
  logic [RING_W-1:0] ring_inc;

  assign fire     = cmd_valid && res_ready;
  assign cmd_pop  = fire;
  assign res_push = fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      disc_en_r  <= 1'b1;
      min_slot_r <= MIN_SLOT_RESET;
    end else if (cfg_wr.we) begin
      case (cfg_wr.index)
        REG_DISC_ENABLE: disc_en_r  <= cfg_wr.data[0];
        REG_MIN_SLOT:    min_slot_r <= cfg_wr.data[MIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Shared arithmetic for the current command.
  assign rdm_side     = state_r inside {ST_RDM, ST_CSH, ST_CSL, ST_DPRE, ST_DUID, ST_DCS};
  assign overrun      = rdm_side && (pos_r >= POS_RDM_LIMIT);
  assign elapsed      = cmd.ts - last_time_r;
  assign gap_clamped  = (elapsed < TS_W'(min_slot_r)) ? TS_W'(min_slot_r) : elapsed;
  assign tick_expired = (state_r == ST_DMX) && (elapsed > gap_r);
  assign pos_inc      = pos_r + POS_W'(1);
  // The length byte counts only once it has actually been received.
  assign len_eff      = (pos_r == POS_LENGTH) ? cmd.data : len_r;
  assign rdm_len_hit  = (pos_inc >= POS_MIN_LENGTH) && (pos_inc == POS_W'(len_eff));
  assign dcnt_inc     = dcnt_r + DCNT_W'(1);
  assign sum_add      = sum_r + SUM_W'(cmd.data);
  assign sum_csh      = sum_r - {cmd.data, 8'h00};
  assign sum_csl      = sum_r - SUM_W'(cmd.data);
  assign ring_inc     = (ring_r == RING_LAST) ? '0 : ring_r + RING_W'(1);

  always_comb begin
    state_nxt = state_r;
    case (cmd.kind)
      REQ_BREAK: state_nxt = ST_BREAK;
      REQ_TICK:  if (tick_expired) state_nxt = ST_IDLE;
      REQ_BYTE: begin
        if (overrun) begin
          state_nxt = ST_IDLE;
        end else begin
          case (state_r)
            ST_IDLE:  if (disc_en_r && cmd.bclass == BC_PREAMBLE) state_nxt = ST_DPRE;
            ST_BREAK: begin
              case (cmd.bclass)
                BC_ZERO:   state_nxt = ST_DMX;
                BC_RDM_SC: state_nxt = ST_RDM;
                default:   state_nxt = ST_IDLE;
              endcase
            end
            ST_DMX:   if (pos_inc > POS_UNIVERSE_END) state_nxt = ST_IDLE;
            ST_RDM:   if (rdm_len_hit) state_nxt = ST_CSH;
            ST_CSH:   state_nxt = ST_CSL;
            ST_CSL:   state_nxt = ST_IDLE;
            ST_DPRE: begin
              case (cmd.bclass)
                BC_SEPARATOR: state_nxt = ST_DUID;
                BC_PREAMBLE:  state_nxt = ST_DPRE;
                default:      state_nxt = ST_IDLE;
              endcase
            end
            ST_DUID:  if (dcnt_inc == DISC_UID_LEN) state_nxt = ST_DCS;
            ST_DCS:   if (dcnt_inc == DISC_CS_LEN) state_nxt = ST_IDLE;
            default: ;
          endcase
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    pos_nxt         = pos_r;
    sum_nxt         = sum_r;
    ring_nxt        = ring_r;
    dcnt_nxt        = dcnt_r;
    len_nxt         = len_r;
    sub_nxt         = sub_r;
    last_time_nxt   = last_time_r;
    brk_time_nxt    = brk_time_r;
    dmx_brk_nxt     = dmx_brk_r;
    brk_was_dmx_nxt = brk_was_dmx_r;
    gap_nxt         = gap_r;
    slots_nxt       = slots_r;
    b2b_nxt         = b2b_r;
    dmx_cnt_nxt     = dmx_cnt_r;
    rdm_cnt_nxt     = rdm_cnt_r;

    res.write_valid  = 1'b0;
    res.write_target = 1'b0;
    res.write_index  = '0;
    res.write_data   = 8'h00;
    res.frame_event  = FE_NONE;

    case (cmd.kind)
      REQ_BREAK: begin
        brk_time_nxt  = cmd.ts;
        last_time_nxt = cmd.ts;
      end
      REQ_TICK: begin
        if (tick_expired) begin
          slots_nxt       = pos_r - POS_W'(1);
          res.frame_event = FE_DMX_DONE;
        end
      end
      REQ_BYTE: begin
        last_time_nxt = cmd.ts;
        if (overrun) begin
          res.frame_event = FE_OVERRUN;
        end else begin
          case (state_r)
            ST_IDLE: begin
              if (disc_en_r && cmd.bclass == BC_PREAMBLE) begin
                res.write_valid  = 1'b1;
                res.write_target = 1'b1;
                res.write_data   = cmd.data;
                pos_nxt          = POS_W'(1);
              end
            end
            ST_BREAK: begin
              case (cmd.bclass)
                BC_ZERO: begin
                  res.write_valid = 1'b1;
                  pos_nxt         = POS_W'(1);
                  dmx_cnt_nxt     = dmx_cnt_r + CNT_W'(1);
                  if (brk_was_dmx_r) b2b_nxt = brk_time_r - dmx_brk_r;
                  brk_was_dmx_nxt = 1'b1;
                  dmx_brk_nxt     = brk_time_r;
                end
                BC_RDM_SC: begin
                  res.write_valid  = 1'b1;
                  res.write_target = 1'b1;
                  res.write_data   = cmd.data;
                  sum_nxt          = SUM_W'(SC_RDM);
                  pos_nxt          = POS_W'(1);
                  rdm_cnt_nxt      = rdm_cnt_r + CNT_W'(1);
                  brk_was_dmx_nxt  = 1'b0;
                end
                default: brk_was_dmx_nxt = 1'b0;
              endcase
            end
            ST_DMX: begin
              gap_nxt         = gap_clamped;
              res.write_valid = 1'b1;
              res.write_index = pos_r;
              res.write_data  = cmd.data;
              pos_nxt         = pos_inc;
              if (pos_inc > POS_UNIVERSE_END) begin
                slots_nxt       = POS_UNIVERSE_END;
                res.frame_event = FE_DMX_DONE;
              end
            end
            ST_RDM: begin
              res.write_valid  = 1'b1;
              res.write_target = 1'b1;
              res.write_index  = pos_r;
              res.write_data   = cmd.data;
              if (pos_r == POS_SUB_CODE) sub_nxt = cmd.data;
              len_nxt = len_eff;
              sum_nxt = sum_add;
              pos_nxt = pos_inc;
            end
            ST_CSH: begin
              res.write_valid  = 1'b1;
              res.write_target = 1'b1;
              res.write_index  = pos_r;
              res.write_data   = cmd.data;
              pos_nxt          = pos_inc;
              sum_nxt          = sum_csh;
            end
            ST_CSL: begin
              res.write_valid  = 1'b1;
              res.write_target = 1'b1;
              res.write_index  = pos_r;
              res.write_data   = cmd.data;
              pos_nxt          = pos_inc;
              sum_nxt          = sum_csl;
              if (sum_csl == '0 && sub_r == RDM_SUB_START) begin
                ring_nxt        = ring_inc;
                res.frame_event = FE_RDM_OK;
              end else begin
                res.frame_event = FE_RDM_BAD;
              end
            end
            ST_DPRE: begin
              if (cmd.bclass == BC_PREAMBLE || cmd.bclass == BC_SEPARATOR) begin
                res.write_valid  = 1'b1;
                res.write_target = 1'b1;
                res.write_index  = pos_r;
                res.write_data   = cmd.data;
                pos_nxt          = pos_inc;
                if (cmd.bclass == BC_SEPARATOR) dcnt_nxt = '0;
              end
            end
            ST_DUID: begin
              res.write_valid  = 1'b1;
              res.write_target = 1'b1;
              res.write_index  = pos_r;
              res.write_data   = cmd.data;
              pos_nxt          = pos_inc;
              dcnt_nxt         = (dcnt_inc == DISC_UID_LEN) ? '0 : dcnt_inc;
            end
            ST_DCS: begin
              res.write_valid  = 1'b1;
              res.write_target = 1'b1;
              res.write_index  = pos_r;
              res.write_data   = cmd.data;
              pos_nxt          = pos_inc;
              dcnt_nxt         = dcnt_inc;
              if (dcnt_inc == DISC_CS_LEN) begin
                ring_nxt        = ring_inc;
                res.frame_event = FE_DISC;
              end
            end
            default: ;
          endcase
        end
      end
      default: ;
    endcase

    res.rdm_slot          = ring_r;
    res.last_frame_slots  = slots_nxt;
    res.break_to_break_us = b2b_nxt;
    res.slot_gap_us       = gap_nxt;
    res.receive_state     = state_nxt;
    res.dmx_packet_count  = dmx_cnt_nxt;
    res.rdm_packet_count  = rdm_cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      pos_r         <= '0;
      sum_r         <= '0;
      ring_r        <= '0;
      dcnt_r        <= '0;
      len_r         <= 8'h00;
      sub_r         <= 8'h00;
      last_time_r   <= '0;
      brk_time_r    <= '0;
      dmx_brk_r     <= '0;
      brk_was_dmx_r <= 1'b0;
      gap_r         <= '0;
      slots_r       <= '0;
      b2b_r         <= '0;
      dmx_cnt_r     <= '0;
      rdm_cnt_r     <= '0;
    end else if (fire) begin
      state_r       <= state_nxt;
      pos_r         <= pos_nxt;
      sum_r         <= sum_nxt;
      ring_r        <= ring_nxt;
      dcnt_r        <= dcnt_nxt;
      len_r         <= len_nxt;
      sub_r         <= sub_nxt;
      last_time_r   <= last_time_nxt;
      brk_time_r    <= brk_time_nxt;
      dmx_brk_r     <= dmx_brk_nxt;
      brk_was_dmx_r <= brk_was_dmx_nxt;
      gap_r         <= gap_nxt;
      slots_r       <= slots_nxt;
      b2b_r         <= b2b_nxt;
      dmx_cnt_r     <= dmx_cnt_nxt;
      rdm_cnt_r     <= rdm_cnt_nxt;
    end
  end

endmodule

FILE: design/drrx_out_buf.sv
// Result side of the frame receiver: a two-entry queue of finished results,
// so the engine can run ahead of the consumer by up to two results while pop is held off.
// Depends on drrx_pkg.
module drrx_out_buf import drrx_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    res_push,
  output logic    res_ready,
  input  result_t res,
  output logic    empty,
  input  logic    pop,
  output result_t head
);

  result_t    q_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;
  logic [1:0] count_nxt;
  logic       do_push, do_pop;

  assign res_ready = (count_r != 2'd2);
  assign empty     = (count_r == 2'd0);
  assign do_push   = res_push && res_ready;
  assign do_pop    = pop && !empty;
  assign head      = q_r[rd_ptr_r];

  always_comb begin
    case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + 2'd1;
      2'b01:   count_nxt = count_r - 2'd1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_push) wr_ptr_r <= !wr_ptr_r;
      if (do_pop)  rd_ptr_r <= !rd_ptr_r;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) q_r[wr_ptr_r] <= res;
  end

endmodule

FILE: design/dmx512_rdm_frame_receiver.sv
// DMX512/RDM frame receiver, top level: front end, engine and result queue.
// A result passes through the command queue and the engine and is registered in the
// result queue before it shows on the result ports; the engine stalls while the
// result queue is full. Throughput: one event per cycle while the result queue has
// room. Reset (synchronous, rst_n low) empties both queues, returns the framer
// to idle and clears all counters. Depends on drrx_pkg, drrx_front, drrx_engine
// and drrx_out_buf.
module dmx512_rdm_frame_receiver import drrx_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [0:0]        cfg_index,
  input  logic [CFG_W-1:0]  cfg_data,
  input  logic              push,
  output logic              full,
  input  logic [1:0]        in_req_type,
  input  logic [7:0]        in_data_byte,
  input  logic [TS_W-1:0]   in_timestamp_us,
  output logic              empty,
  input  logic              pop,
  output logic              out_write_valid,
  output logic              out_write_target,
  output logic [POS_W-1:0]  out_write_index,
  output logic [7:0]        out_write_data,
  output logic [RING_W-1:0] out_rdm_slot,
  output logic [2:0]        out_frame_event,
  output logic [POS_W-1:0]  out_last_frame_slots,
  output logic [TS_W-1:0]   out_break_to_break_us,
  output logic [TS_W-1:0]   out_slot_gap_us,
  output logic [3:0]        out_receive_state,
  output logic [CNT_W-1:0]  out_dmx_packet_count,
  output logic [CNT_W-1:0]  out_rdm_packet_count
);

  cfg_wr_t cfg_wr;
  cmd_t    cmd;
  logic    cmd_valid, cmd_pop;
  result_t res, head;
  logic    res_push, res_ready;

  assign cfg_wr.we    = cfg_we;
  assign cfg_wr.index = cfg_reg_t'(cfg_index);
  assign cfg_wr.data  = cfg_data;

  drrx_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .full            (full),
    .in_req_type     (in_req_type),
    .in_data_byte    (in_data_byte),
    .in_timestamp_us (in_timestamp_us),
    .cmd_valid       (cmd_valid),
    .cmd_pop         (cmd_pop),
    .cmd             (cmd)
  );

  drrx_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr    (cfg_wr),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .cmd       (cmd),
    .res_ready (res_ready),
    .res_push  (res_push),
    .res       (res)
  );

  drrx_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_push  (res_push),
    .res_ready (res_ready),
    .res       (res),
    .empty     (empty),
    .pop       (pop),
    .head      (head)
  );

  assign out_write_valid       = head.write_valid;
  assign out_write_target      = head.write_target;
  assign out_write_index       = head.write_index;
  assign out_write_data        = head.write_data;
  assign out_rdm_slot          = head.rdm_slot;
  assign out_frame_event       = head.frame_event;
  assign out_last_frame_slots  = head.last_frame_slots;
  assign out_break_to_break_us = head.break_to_break_us;
  assign out_slot_gap_us       = head.slot_gap_us;
  assign out_receive_state     = head.receive_state;
  assign out_dmx_packet_count  = head.dmx_packet_count;
  assign out_rdm_packet_count  = head.rdm_packet_count;

endmodule

FILE: design/drrx_checker.sv
// Port-level checks for the DMX512/RDM frame receiver, attached by bind.
// Depends on drrx_pkg and dmx512_rdm_frame_receiver.
module drrx_checker import drrx_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              empty,
  input logic              pop,
  input logic              out_write_valid,
  input logic              out_write_target,
  input logic [POS_W-1:0]  out_write_index,
  input logic [7:0]        out_write_data,
  input logic [2:0]        out_frame_event,
  input logic [3:0]        out_receive_state
);

  // A transaction without a buffer write carries a cleared write payload.
  a_idle_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && !out_write_valid |->
      out_write_target == 1'b0 && out_write_index == '0 && out_write_data == 8'h00)
    else $error("write fields not cleared without write_valid");

  // Every frame outcome leaves the receiver idle.
  a_event_ends_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && out_frame_event != FE_NONE |-> out_receive_state == ST_IDLE)
    else $error("frame event reported while not idle");

  // Write positions never pass the end of a DMX universe.
  a_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && out_write_valid |-> out_write_index <= POS_UNIVERSE_END)
    else $error("write index out of range");

  // Reset leaves the result queue empty.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> empty)
    else $error("results present right after reset");

  // A waiting result stays put until it is popped.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && !pop |=> !empty && $stable(out_write_data) && $stable(out_frame_event))
    else $error("pending result changed before pop");

endmodule

bind dmx512_rdm_frame_receiver drrx_checker u_drrx_checker (.*);

FILE: tb/sv/tb_top.sv
// Self-checking testbench for the DMX512/RDM frame receiver: a table of opening
// events, then randomized DMX, RDM and discovery traffic checked against a framer
// model kept here. Depends on drrx_pkg and dmx512_rdm_frame_receiver.
`timescale 1ns / 100ps

module tb_top;
  import drrx_pkg::*;

  localparam int QUIET_LIMIT = 3000;
  localparam int BACKLOG_HOLD = 300;

  typedef struct {
    req_type_t    kind;
    logic [7:0]   data;
    logic [31:0]  ts;
    logic         pinned;
    rx_state_t    want_state;
    frame_event_t want_event;
  } stim_row_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_we = 1'b0;
  cfg_reg_t          cfg_index = REG_DISC_ENABLE;
  logic [CFG_W-1:0]  cfg_data = '0;
  logic              push = 1'b0;
  logic              full;
  logic [1:0]        in_req_type = 2'd0;
  logic [7:0]        in_data_byte = 8'd0;
  logic [TS_W-1:0]   in_timestamp_us = '0;
  logic              empty;
  logic              pop = 1'b0;
  logic              out_write_valid;
  logic              out_write_target;
  logic [POS_W-1:0]  out_write_index;
  logic [7:0]        out_write_data;
  logic [RING_W-1:0] out_rdm_slot;
  logic [2:0]        out_frame_event;
  logic [POS_W-1:0]  out_last_frame_slots;
  logic [TS_W-1:0]   out_break_to_break_us;
  logic [TS_W-1:0]   out_slot_gap_us;
  logic [3:0]        out_receive_state;
  logic [CNT_W-1:0]  out_dmx_packet_count;
  logic [CNT_W-1:0]  out_rdm_packet_count;

  // Values typed into the opening table ride along with their transaction.
  logic              pin_valid = 1'b0;
  rx_state_t         pin_state = ST_IDLE;
  frame_event_t      pin_event = FE_NONE;

  // Framer model state and its copy of the registers.
  logic              cf_disc_en = 1'b1;
  logic [MIN_W-1:0]  cf_min_slot = MIN_SLOT_RESET;
  rx_state_t         fr_state = ST_IDLE;
  logic [POS_W-1:0]  fr_pos = '0;
  logic [SUM_W-1:0]  fr_sum = '0;
  logic [RING_W-1:0] fr_head = '0;
  logic [DCNT_W-1:0] fr_disc = '0;
  logic [7:0]        fr_len = '0;
  logic [7:0]        fr_sub = '0;
  logic [31:0]       fr_last_ts = '0;
  logic [31:0]       fr_break_ts = '0;
  logic [31:0]       fr_dmx_break_ts = '0;
  logic              fr_was_dmx = 1'b0;
  logic [31:0]       fr_gap = '0;
  logic [POS_W-1:0]  fr_slots = '0;
  logic [31:0]       fr_interval = '0;
  logic [31:0]       fr_dmx_cnt = '0;
  logic [31:0]       fr_rdm_cnt = '0;

  result_t           pending_results [$];
  int                results_seen = 0;
  int                events_taken = 0;
  int                mismatches = 0;
  int                ev_seen [8];
  int                quiet_cycles = 0;
  int                items_sent = 0;
  int                settings_used = 1;
  logic [31:0]      line_time_us = '0;

  stim_row_t opening_rows [26] = '{
    '{REQ_TICK,  8'h00, 32'd0,          1'b1, ST_IDLE,  FE_NONE},
    '{REQ_NONE,  8'hFF, 32'hFFFF_FFFF,  1'b1, ST_IDLE,  FE_NONE},
    '{REQ_BREAK, 8'h00, 32'd100,        1'b1, ST_BREAK, FE_NONE},
    '{REQ_BYTE,  8'h00, 32'd200,        1'b1, ST_DMX,   FE_NONE},
    '{REQ_BYTE,  8'hFF, 32'd210,        1'b0, ST_IDLE,  FE_NONE},
    '{REQ_BYTE,  8'h80, 32'd400,        1'b0, ST_IDLE,  FE_NONE},
    '{REQ_TICK,  8'h00, 32'd500,        1'b1, ST_DMX,   FE_NONE},
    '{REQ_TICK,  8'h00, 32'd591,        1'b1, ST_IDLE,  FE_DMX_DONE},
    '{REQ_BREAK, 8'h00, 32'd1000,       1'b0, ST_IDLE,  FE_NONE},
    '{REQ_BYTE,  8'h00, 32'd1044,       1'b1, ST_DMX,   FE_NONE},
    '{REQ_BREAK, 8'h00, 32'd2000,       1'b1, ST_BREAK, FE_NONE},
    '{REQ_BYTE,  8'h55, 32'd2044,       1'b1, ST_IDLE,  FE_NONE},
    '{REQ_BREAK, 8'h00, 32'd3000,       1'b0, ST_IDLE,  FE_NONE},
    '{REQ_BYTE,  8'hCC, 32'd3044,       1'b1, ST_RDM,   FE_NONE},
    '{REQ_BYTE,  8'h01, 32'd3088,       1'b0, ST_IDLE,  FE_NONE},
    '{REQ_BYTE,  8'h03, 32'd3132,       1'b1, ST_CSH,   FE_NONE},
    '{REQ_BYTE,  8'h00, 32'd3176,       1'b1, ST_CSL,   FE_NONE},
    '{REQ_BYTE,  8'hD0, 32'd3220,       1'b1, ST_IDLE,  FE_RDM_OK},
    '{REQ_BREAK, 8'h00, 32'd4000,       1'b0, ST_IDLE,  FE_NONE},
    '{REQ_BYTE,  8'hCC, 32'd4044,       1'b0, ST_IDLE,  FE_NONE},
    '{REQ_BYTE,  8'h02, 32'd4088,       1'b0, ST_IDLE,  FE_NONE},
    '{REQ_BYTE,  8'h03, 32'd4132,       1'b0, ST_IDLE,  FE_NONE},
    '{REQ_BYTE,  8'h00, 32'd4176,       1'b0, ST_IDLE,  FE_NONE},
    '{REQ_BYTE,  8'hD1, 32'd4220,       1'b1, ST_IDLE,  FE_RDM_BAD},
    '{REQ_BYTE,  8'hFE, 32'd5000,       1'b1, ST_DPRE,  FE_NONE},
    '{REQ_BYTE,  8'h12, 32'd5044,       1'b1, ST_IDLE,  FE_NONE}
  };

  dmx512_rdm_frame_receiver uut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data),
    .push                  (push),
    .full                  (full),
    .in_req_type           (in_req_type),
    .in_data_byte          (in_data_byte),
    .in_timestamp_us       (in_timestamp_us),
    .empty                 (empty),
    .pop                   (pop),
    .out_write_valid       (out_write_valid),
    .out_write_target      (out_write_target),
    .out_write_index       (out_write_index),
    .out_write_data        (out_write_data),
    .out_rdm_slot          (out_rdm_slot),
    .out_frame_event       (out_frame_event),
    .out_last_frame_slots  (out_last_frame_slots),
    .out_break_to_break_us (out_break_to_break_us),
    .out_slot_gap_us       (out_slot_gap_us),
    .out_receive_state     (out_receive_state),
    .out_dmx_packet_count  (out_dmx_packet_count),
    .out_rdm_packet_count  (out_rdm_packet_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [RING_W-1:0] next_ring(logic [RING_W-1:0] head);
    return (head == RING_LAST) ? '0 : head + 1'b1;
  endfunction

  // Advances the framer model by one event and returns the result it reports.
  function automatic result_t rx_frame_step(req_type_t kind, logic [7:0] b,
                                            logic [31:0] ts);
    result_t          r;
    logic [31:0]      gap;
    logic             store;
    logic             to_rdm;
    logic [POS_W-1:0] idx;
    frame_event_t     ev;
    r = '0;
    store = 1'b0;
    to_rdm = 1'b1;
    idx = fr_pos;
    ev = FE_NONE;
    r.rdm_slot = fr_head;
    case (kind)
      REQ_BREAK: begin
        fr_state = ST_BREAK;
        fr_break_ts = ts;
        fr_last_ts = ts;
      end
      REQ_TICK: begin
        if (fr_state == ST_DMX && (ts - fr_last_ts) > fr_gap) begin
          fr_state = ST_IDLE;
          fr_slots = fr_pos - 1'b1;
          ev = FE_DMX_DONE;
        end
      end
      REQ_BYTE: begin
        if (fr_state >= ST_RDM && fr_state <= ST_DCS && fr_pos >= POS_RDM_LIMIT) begin
          fr_state = ST_IDLE;
          ev = FE_OVERRUN;
        end else begin
          case (fr_state)
            ST_IDLE: begin
              if (cf_disc_en && b == DISC_PREAMBLE) begin
                fr_state = ST_DPRE;
                store = 1'b1;
                idx = '0;
                fr_pos = POS_W'(1);
              end
            end
            ST_BREAK: begin
              if (b == SC_DMX) begin
                fr_state = ST_DMX;
                store = 1'b1;
                to_rdm = 1'b0;
                idx = '0;
                fr_pos = POS_W'(1);
                fr_dmx_cnt = fr_dmx_cnt + 1;
                if (fr_was_dmx) fr_interval = fr_break_ts - fr_dmx_break_ts;
                fr_was_dmx = 1'b1;
                fr_dmx_break_ts = fr_break_ts;
              end else if (b == SC_RDM) begin
                fr_state = ST_RDM;
                store = 1'b1;
                idx = '0;
                fr_sum = SUM_W'(SC_RDM);
                fr_pos = POS_W'(1);
                fr_rdm_cnt = fr_rdm_cnt + 1;
                fr_was_dmx = 1'b0;
              end else begin
                fr_state = ST_IDLE;
                fr_was_dmx = 1'b0;
              end
            end
            ST_DMX: begin
              gap = ts - fr_last_ts;
              if (gap < 32'(cf_min_slot)) gap = 32'(cf_min_slot);
              fr_gap = gap;
              store = 1'b1;
              to_rdm = 1'b0;
              fr_pos = fr_pos + 1'b1;
              if (fr_pos > POS_UNIVERSE_END) begin
                fr_state = ST_IDLE;
                fr_slots = POS_UNIVERSE_END;
                ev = FE_DMX_DONE;
              end
            end
            ST_RDM: begin
              store = 1'b1;
              if (fr_pos == POS_SUB_CODE) fr_sub = b;
              if (fr_pos == POS_LENGTH) fr_len = b;
              fr_sum = fr_sum + b;
              fr_pos = fr_pos + 1'b1;
              if (fr_pos >= POS_MIN_LENGTH && fr_pos == POS_W'(fr_len)) fr_state = ST_CSH;
            end
            ST_CSH: begin
              store = 1'b1;
              fr_pos = fr_pos + 1'b1;
              fr_sum = fr_sum - {b, 8'h00};
              fr_state = ST_CSL;
            end
            ST_CSL: begin
              store = 1'b1;
              fr_pos = fr_pos + 1'b1;
              fr_sum = fr_sum - b;
              if (fr_sum == '0 && fr_sub == RDM_SUB_START) begin
                fr_head = next_ring(fr_head);
                ev = FE_RDM_OK;
              end else begin
                ev = FE_RDM_BAD;
              end
              fr_state = ST_IDLE;
            end
            ST_DPRE: begin
              if (b == DISC_PREAMBLE || b == DISC_SEPARATOR) begin
                store = 1'b1;
                fr_pos = fr_pos + 1'b1;
                if (b == DISC_SEPARATOR) begin
                  fr_state = ST_DUID;
                  fr_disc = '0;
                end
              end else begin
                fr_state = ST_IDLE;
              end
            end
            ST_DUID: begin
              store = 1'b1;
              fr_pos = fr_pos + 1'b1;
              fr_disc = fr_disc + 1'b1;
              if (fr_disc == DISC_UID_LEN) begin
                fr_state = ST_DCS;
                fr_disc = '0;
              end
            end
            ST_DCS: begin
              store = 1'b1;
              fr_pos = fr_pos + 1'b1;
              fr_disc = fr_disc + 1'b1;
              if (fr_disc == DISC_CS_LEN) begin
                fr_head = next_ring(fr_head);
                fr_state = ST_IDLE;
                ev = FE_DISC;
              end
            end
            default: ;
          endcase
        end
        fr_last_ts = ts;
      end
      default: ;
    endcase
    if (store) begin
      r.write_valid = 1'b1;
      r.write_target = to_rdm;
      r.write_index = idx;
      r.write_data = b;
    end
    r.frame_event = ev;
    r.last_frame_slots = fr_slots;
    r.break_to_break_us = fr_interval;
    r.slot_gap_us = fr_gap;
    r.receive_state = fr_state;
    r.dmx_packet_count = fr_dmx_cnt;
    r.rdm_packet_count = fr_rdm_cnt;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatches++;
    if (mismatches <= 40)
      $display("%0t ns: MISMATCH %s: got 0x%0h, wanted 0x%0h", $time, what, got, want);
  endtask

  task automatic check_field(string what, logic [31:0] got, logic [31:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  // Scoreboard: results are compared before the event of the same edge is modeled.
  always @(posedge clk) begin : scoreboard
    result_t want;
    if (rst_n) begin
      if (pop && empty === 1'b0) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result with nothing pending", 32'(out_write_index), 32'd0);
        end else begin
          want = pending_results.pop_front();
          check_field("write_valid", 32'(out_write_valid), 32'(want.write_valid));
          check_field("write_target", 32'(out_write_target), 32'(want.write_target));
          check_field("write_index", 32'(out_write_index), 32'(want.write_index));
          check_field("write_data", 32'(out_write_data), 32'(want.write_data));
          check_field("rdm_slot", 32'(out_rdm_slot), 32'(want.rdm_slot));
          check_field("frame_event", 32'(out_frame_event), 32'(want.frame_event));
          check_field("last_frame_slots", 32'(out_last_frame_slots),
                      32'(want.last_frame_slots));
          check_field("break_to_break_us", out_break_to_break_us, want.break_to_break_us);
          check_field("slot_gap_us", out_slot_gap_us, want.slot_gap_us);
          check_field("receive_state", 32'(out_receive_state), 32'(want.receive_state));
          check_field("dmx_packet_count", out_dmx_packet_count, want.dmx_packet_count);
          check_field("rdm_packet_count", out_rdm_packet_count, want.rdm_packet_count);
        end
        results_seen <= results_seen + 1;
      end
      if (cfg_we) begin
        if (cfg_index == REG_DISC_ENABLE) cf_disc_en = cfg_data[0];
        else cf_min_slot = cfg_data[MIN_W-1:0];
      end
      if (push && full === 1'b0) begin
        want = rx_frame_step(req_type_t'(in_req_type), in_data_byte, in_timestamp_us);
        if (pin_valid) begin
          want.frame_event = pin_event;
          want.receive_state = pin_state;
        end
        ev_seen[want.frame_event]++;
        events_taken++;
        pending_results.push_back(want);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((push && full === 1'b0) || (pop && empty === 1'b0)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Watchdog: no transaction for %0d cycles, %0d results still pending",
                 QUIET_LIMIT, pending_results.size());
        $display("Simulation FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Result side: random stalls, one long backlog hold, and a stretch of steady pops.
  initial begin : result_drain
    int hold_left;
    int stall_left;
    int r;
    bit backlog_done;
    hold_left = 0;
    stall_left = 0;
    backlog_done = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        pop <= 1'b0;
        hold_left--;
      end else if (!backlog_done && results_seen >= 100) begin
        backlog_done = 1'b1;
        hold_left = BACKLOG_HOLD - 1;
        pop <= 1'b0;
      end else if (stall_left > 0) begin
        pop <= 1'b0;
        stall_left--;
      end else if (results_seen >= 800 && results_seen < 1000) begin
        pop <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 65) begin
          pop <= 1'b1;
        end else begin
          pop <= 1'b0;
          stall_left = (r < 95) ? $urandom_range(0, 2) : $urandom_range(15, 50);
        end
      end
    end
  end

  function automatic int sender_gap();
    int r;
    if (items_sent >= 300 && items_sent < 450) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Offers one event and returns at the edge where it is taken; push stays high
  // so that a following event can go out back to back.
  task automatic send_event(req_type_t kind, logic [7:0] b, logic [31:0] ts,
                            logic pinned, rx_state_t st, frame_event_t ev);
    int gap;
    gap = sender_gap();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    in_req_type <= kind;
    in_data_byte <= b;
    in_timestamp_us <= ts;
    pin_valid <= pinned;
    pin_state <= st;
    pin_event <= ev;
    @(posedge clk);
    while (full !== 1'b0) @(posedge clk);
    if (kind != REQ_NONE) items_sent++;
  endtask

  task automatic send_after(req_type_t kind, logic [7:0] b, int unsigned delta);
    line_time_us = line_time_us + delta;
    send_event(kind, b, line_time_us, 1'b0, ST_IDLE, FE_NONE);
  endtask

  function automatic int unsigned slot_delta();
    if ($urandom_range(0, 9) != 0) return $urandom_range(1, 120);
    return $urandom_range(121, 5000);
  endfunction

  task automatic dmx_frame(int slots);
    int i;
    send_after(REQ_BREAK, 8'($urandom), $urandom_range(88, 400));
    send_after(REQ_BYTE, SC_DMX, $urandom_range(12, 100));
    for (i = 0; i < slots; i++) send_after(REQ_BYTE, 8'($urandom), slot_delta());
    if ($urandom_range(0, 9) < 7) begin
      send_after(REQ_TICK, 8'($urandom), $urandom_range(0, 60));
      send_after(REQ_TICK, 8'($urandom), $urandom_range(40, 6000));
    end
  endtask

  // A well-formed packet most of the time; otherwise a wrong sub start code, a bad
  // checksum, or a length below three that never closes the packet.
  task automatic rdm_packet(bit overrun);
    logic [7:0]  sub;
    logic [7:0]  len;
    logic [7:0]  b;
    logic [15:0] sum;
    int          i;
    int          n;
    int          r;
    r = $urandom_range(0, 99);
    sub = (r < 88) ? RDM_SUB_START : 8'($urandom);
    r = $urandom_range(0, 99);
    if (overrun || r >= 90) len = 8'($urandom_range(0, 2));
    else if (r < 85) len = 8'($urandom_range(3, 26));
    else len = 8'($urandom_range(27, 255));
    send_after(REQ_BREAK, 8'($urandom), $urandom_range(88, 400));
    send_after(REQ_BYTE, SC_RDM, $urandom_range(12, 100));
    send_after(REQ_BYTE, sub, slot_delta());
    send_after(REQ_BYTE, len, slot_delta());
    if (len < 3) begin
      n = overrun ? 512 : $urandom_range(0, 12);
      for (i = 0; i < n; i++) send_after(REQ_BYTE, 8'($urandom), $urandom_range(1, 60));
      return;
    end
    sum = SC_RDM + sub + len;
    for (i = 3; i < len; i++) begin
      b = 8'($urandom);
      sum = sum + b;
      send_after(REQ_BYTE, b, slot_delta());
    end
    if ($urandom_range(0, 9) == 0) sum = sum ^ 16'($urandom_range(1, 65535));
    send_after(REQ_BYTE, sum[15:8], slot_delta());
    send_after(REQ_BYTE, sum[7:0], slot_delta());
  endtask

  task automatic discovery_reply();
    logic [7:0] b;
    int         i;
    int         n;
    // A break with an unknown start code leaves the framer idle.
    do b = 8'($urandom); while (b == SC_DMX || b == SC_RDM);
    send_after(REQ_BREAK, 8'($urandom), $urandom_range(88, 400));
    send_after(REQ_BYTE, b, $urandom_range(12, 100));
    send_after(REQ_BYTE, DISC_PREAMBLE, $urandom_range(1, 2000));
    n = $urandom_range(0, 6);
    for (i = 0; i < n; i++) send_after(REQ_BYTE, DISC_PREAMBLE, $urandom_range(1, 60));
    if ($urandom_range(0, 9) == 0) begin
      send_after(REQ_BYTE, 8'($urandom), $urandom_range(1, 60));
      return;
    end
    send_after(REQ_BYTE, DISC_SEPARATOR, $urandom_range(1, 60));
    for (i = 0; i < 16; i++) send_after(REQ_BYTE, 8'($urandom), $urandom_range(1, 60));
  endtask

  task automatic line_noise();
    int i;
    int n;
    n = $urandom_range(1, 8);
    for (i = 0; i < n; i++)
      send_after(req_type_t'($urandom_range(0, 3)), 8'($urandom), $urandom_range(0, 3000));
  endtask

  task automatic run_traffic(int budget, bit with_long);
    int target;
    int step;
    int r;
    target = items_sent + budget;
    step = 0;
    while (items_sent < target) begin
      step++;
      r = $urandom_range(0, 99);
      if (r < 4) line_time_us = $urandom();
      else if (r == 4) line_time_us = 32'hFFFF_FFFF - $urandom_range(0, 2000);
      r = $urandom_range(0, 99);
      if (with_long && step == 2) dmx_frame($urandom_range(UNIVERSE_SLOTS, UNIVERSE_SLOTS + 4));
      else if (with_long && step == 5) rdm_packet(1'b1);
      else if (r < 30) dmx_frame(($urandom_range(0, 9) != 0) ? $urandom_range(0, 24)
                                                               : $urandom_range(25, 120));
      else if (r < 60) rdm_packet(1'b0);
      else if (r < 82) discovery_reply();
      else line_noise();
    end
  endtask

  // Registers change only once every pending result has come back.
  task automatic set_register(cfg_reg_t idx, logic [CFG_W-1:0] value);
    push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (opening_rows[i])
      send_event(opening_rows[i].kind, opening_rows[i].data, opening_rows[i].ts,
                 opening_rows[i].pinned, opening_rows[i].want_state,
                 opening_rows[i].want_event);
    line_time_us = 32'd6000;
    // The long DMX frame and the overrun packet alone take over a thousand events.
    run_traffic(600, 1'b1);
    set_register(REG_DISC_ENABLE, CFG_W'(0));
    set_register(REG_MIN_SLOT, CFG_W'(1));
    run_traffic(70, 1'b0);
    set_register(REG_DISC_ENABLE, CFG_W'(1));
    set_register(REG_MIN_SLOT, CFG_W'(1000));
    run_traffic(70, 1'b0);
    set_register(REG_DISC_ENABLE, CFG_W'($urandom_range(0, 1023)));
    set_register(REG_MIN_SLOT, CFG_W'($urandom_range(1, 1000)));
    settings_used = 4;
    run_traffic(60, 1'b0);
    push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("Checked %0d results for %0d events over %0d register settings, %0d mismatches",
             results_seen, events_taken, settings_used, mismatches);
    $display("Frame ends: %0d DMX, %0d RDM good, %0d RDM bad, %0d discovery, %0d overrun",
             ev_seen[FE_DMX_DONE], ev_seen[FE_RDM_OK], ev_seen[FE_RDM_BAD],
             ev_seen[FE_DISC], ev_seen[FE_OVERRUN]);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
design/drrx_pkg.sv
design/drrx_front.sv
design/drrx_engine.sv
design/drrx_out_buf.sv
design/dmx512_rdm_frame_receiver.sv
design/drrx_checker.sv
tb/sv/tb_top.sv
